// ===== sv/ic3_pkg.sv =====
`timescale 1ns / 1ps

package ic3_pkg;

   // Frame geometry
   localparam int MAX_WIDTH   = 1024;
   localparam int KERNEL_SIZE = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);

   // Field widths
   localparam int PIX_W      = 8;
   localparam int WIDTH_W    = 11;
   localparam int ROW_W      = 16;
   localparam int OUT_COL_W  = 10;
   localparam int KSEL_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Signed accumulator: covers -2040..4080 for every kernel
   localparam int SUM_W = 13;

   // ceil(2^16 / 9); exact floor for sums up to 9 * 255
   localparam int             RECIP_SHIFT = 16;
   localparam logic [15:0]    RECIP_NINE  = 16'd7282;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SELECT = 2'd2;

   // Register reset values
   localparam logic [WIDTH_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [ROW_W-1:0]   RESET_HEIGHT = 16'd480;

   // Kernel codes
   localparam logic [KSEL_W-1:0] KERNEL_BOX      = 3'd0;
   localparam logic [KSEL_W-1:0] KERNEL_GAUSSIAN = 3'd1;
   localparam logic [KSEL_W-1:0] KERNEL_OUTLINE  = 3'd2;
   localparam logic [KSEL_W-1:0] KERNEL_EMBOSS   = 3'd3;
   localparam logic [KSEL_W-1:0] KERNEL_SHARPEN  = 3'd4;

   // One line store entry: the previous row and the row before it
   typedef struct packed {
      logic [PIX_W-1:0] prev;
      logic [PIX_W-1:0] older;
   } line_type;

   // Per-pixel bookkeeping carried down the pipeline
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             border;
      logic             interior;
      logic             last_pixel;
   } meta_type;

endpackage

// ===== sv/image_convolution_3x3.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_pixel_in
// rsp_      out        rsp_valid/rsp_stall  rsp_pixel_out, rsp_out_row, rsp_out_column,
//                                           rsp_last_of_run, rsp_frame_end
// csr_      in         csr_write_en         csr_index, csr_data (write only)
//
// One pixel per clock while the output does not stall; each result is registered through every stage.
// The line store is a simple dual-port memory, read when a pixel is taken and written
// back as it leaves stage 1, with forwarding when the same column follows directly.
// From row 2 and column 2 on, a pixel in the last row or column gives two results, so
// the output port limits intake there. Reset clears counters, window and valids and loads the register defaults only.
// A stall on the output holds the last stage and fills the earlier ones before req_stall rises.

module image_convolution_3x3
   import ic3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [OUT_COL_W-1:0]  rsp_out_column,
   output logic                  rsp_last_of_run,
   output logic                  rsp_frame_end,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers
   logic [WIDTH_W-1:0] csr_width_ff;
   logic [ROW_W-1:0]   csr_height_ff;
   logic [KSEL_W-1:0]  csr_kernel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= RESET_WIDTH;
         csr_height_ff <= RESET_HEIGHT;
         csr_kernel_ff <= KERNEL_BOX;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   csr_width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  csr_height_ff <= csr_data[ROW_W-1:0];
            CSR_KERNEL_SELECT: csr_kernel_ff <= csr_data[KSEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size
   logic [WIDTH_W-1:0] w_eff;
   logic [ROW_W-1:0]   h_eff;

   always_comb begin
      w_eff = csr_width_ff;
      if (csr_width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (csr_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end
      h_eff = (csr_height_ff == '0) ? ROW_W'(1) : csr_height_ff;
   end

   // Pipeline control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_adv, s2_adv, s3_adv;
   logic s1_free, s2_free, s3_free, s4_free;
   logic req_accept, rsp_accept, s4_done;
   logic show_border, res_last;

   meta_type s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff;

   assign rsp_accept = s4_valid_ff && !rsp_stall;
   assign s4_done    = rsp_accept && res_last;
   assign s4_free    = !s4_valid_ff || s4_done;
   assign s3_free    = !s3_valid_ff || s4_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s3_adv     = s3_valid_ff && s4_free;
   assign s2_adv     = s2_valid_ff && s3_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && !req_stall;

   // Position of the incoming pixel, with wrap for a shrunk frame size
   logic [COL_W-1:0] col_ff, col_in, cur_col;
   logic [ROW_W-1:0] row_ff, row_in, cur_row;
   logic [ROW_W:0]   row_wrap;
   logic             col_end, row_end;
   meta_type         cur_meta;

   always_comb begin
      cur_col  = col_ff;
      row_wrap = {1'b0, row_ff};
      if (WIDTH_W'(col_ff) >= w_eff) begin
         cur_col  = '0;
         row_wrap = {1'b0, row_ff} + 1'b1;
      end
      cur_row = (row_wrap >= {1'b0, h_eff}) ? '0 : row_wrap[ROW_W-1:0];
      col_end = (WIDTH_W'(cur_col) + WIDTH_W'(1)) >= w_eff;
      row_end = ({1'b0, cur_row} + 1'b1) >= {1'b0, h_eff};
      col_in  = col_end ? '0 : cur_col + 1'b1;
      row_in  = col_end ? (row_end ? '0 : cur_row + 1'b1) : cur_row;

      cur_meta.pix        = req_pixel_in;
      cur_meta.row        = cur_row;
      cur_meta.col        = cur_col;
      cur_meta.border     = (cur_row == '0) || row_end || (cur_col == '0) || col_end;
      cur_meta.interior   = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      cur_meta.last_pixel = row_end && col_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store: read on request, written back as stage 1 moves on
   line_type line_mem_ff [MAX_WIDTH];
   line_type rd_data_ff, fwd_data_ff, rd_line, wr_data;
   logic     fwd_ff;

   assign rd_line = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_data = '{prev: s1_meta_ff.pix, older: rd_line.prev};

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff  <= line_mem_ff[cur_col];
         fwd_ff      <= s1_adv && (s1_meta_ff.col == cur_col);
         fwd_data_ff <= wr_data;
      end
      if (s1_adv) begin
         line_mem_ff[s1_meta_ff.col] <= wr_data;
      end
   end

   // Stage valids and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= req_accept;
         if (s2_free) s2_valid_ff <= s1_adv;
         if (s3_free) s3_valid_ff <= s2_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) s1_meta_ff <= cur_meta;
      if (s1_adv)     s2_meta_ff <= s1_meta_ff;
      if (s2_adv)     s3_meta_ff <= s2_meta_ff;
   end

   // Window: shift left, new column from the line store and the pixel
   logic [PIX_W-1:0] win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [PIX_W-1:0] win_in [KERNEL_SIZE][KERNEL_SIZE];

   always_comb begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
            win_in[i][j] = win_ff[i][j+1];
         end
      end
      win_in[0][KERNEL_SIZE-1] = rd_line.older;
      win_in[1][KERNEL_SIZE-1] = rd_line.prev;
      win_in[2][KERNEL_SIZE-1] = s1_meta_ff.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // Stage 2: weighted sum over the window
   logic signed [SUM_W-1:0] t [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [SUM_W-1:0] sum_in, sum_ff;

   always_comb begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            t[i][j] = signed'(SUM_W'(win_ff[i][j]));
         end
      end
      case (csr_kernel_ff)
         KERNEL_BOX: begin
            sum_in = t[0][0] + t[0][1] + t[0][2] + t[1][0] + t[1][1] + t[1][2]
                   + t[2][0] + t[2][1] + t[2][2];
         end
         KERNEL_GAUSSIAN: begin
            sum_in = t[0][0] + t[0][2] + t[2][0] + t[2][2]
                   + ((t[0][1] + t[1][0] + t[1][2] + t[2][1]) <<< 1)
                   + (t[1][1] <<< 2);
         end
         KERNEL_OUTLINE: begin
            sum_in = (t[1][1] <<< 3) - t[0][0] - t[0][1] - t[0][2] - t[1][0]
                   - t[1][2] - t[2][0] - t[2][1] - t[2][2];
         end
         KERNEL_EMBOSS: begin
            sum_in = (t[2][2] <<< 1) - (t[0][0] <<< 1) - t[0][1] - t[1][0]
                   + t[1][1] + t[1][2] + t[2][1];
         end
         KERNEL_SHARPEN: begin
            sum_in = (t[1][1] <<< 2) + t[1][1] - t[0][1] - t[1][0] - t[1][2] - t[2][1];
         end
         default: sum_in = t[1][1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_adv) sum_ff <= sum_in;
   end

   // Stage 3: scale and clamp
   logic [SUM_W+15:0]       prod;
   logic signed [SUM_W-1:0] scaled;
   logic [PIX_W-1:0]        conv_in, s4_conv_ff;

   always_comb begin
      prod = (SUM_W+16)'(sum_ff[SUM_W-2:0]) * (SUM_W+16)'(RECIP_NINE);
      case (csr_kernel_ff)
         KERNEL_BOX:      scaled = signed'(prod[SUM_W+RECIP_SHIFT-1:RECIP_SHIFT]);
         KERNEL_GAUSSIAN: scaled = sum_ff >>> 4;
         default:         scaled = sum_ff;
      endcase
      if (scaled < 0) begin
         conv_in = '0;
      end else if (scaled > SUM_W'(255)) begin
         conv_in = '1;
      end else begin
         conv_in = scaled[PIX_W-1:0];
      end
   end

   // Stage 4: output register, border copy first, then the interior result
   logic s4_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s4_second_ff <= 1'b0;
      end else begin
         if (rsp_accept && !res_last) s4_second_ff <= 1'b1;
         if (s4_free) begin
            s4_valid_ff  <= s3_adv && (s3_meta_ff.border || s3_meta_ff.interior);
            s4_second_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv && s4_free) begin
         s4_meta_ff <= s3_meta_ff;
         s4_conv_ff <= conv_in;
      end
   end

   assign show_border = s4_meta_ff.border && !s4_second_ff;
   assign res_last    = !show_border || !s4_meta_ff.interior;

   assign rsp_valid       = s4_valid_ff;
   assign rsp_pixel_out   = show_border ? s4_meta_ff.pix : s4_conv_ff;
   assign rsp_out_row     = show_border ? s4_meta_ff.row : s4_meta_ff.row - 1'b1;
   assign rsp_out_column  = OUT_COL_W'(show_border ? s4_meta_ff.col : s4_meta_ff.col - 1'b1);
   assign rsp_last_of_run = res_last;
   assign rsp_frame_end   = res_last && s4_meta_ff.last_pixel;

   // Checks
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("interior result did not follow border copy");

   a_request_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted request lost before stage 1");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff)
      else $error("request stalled with a free pipeline stage");

endmodule

// ===== test/tb_image_convolution_3x3.sv =====
`timescale 1ns / 1ps

module tb_image_convolution_3x3
   import ic3_pkg::*;
();

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PIXELS = 1100;
   // Kernel code past the defined set: centre passes through
   localparam logic [KSEL_W-1:0] KERNEL_UNKNOWN = 3'd7;
   // Register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Fixed contrast pattern for the 3-wide directed frame
   localparam logic [PIX_W-1:0] DIRECTED_PIX [24] = '{
      8'd255, 8'd255, 8'd255,  8'd255, 8'd0,   8'd255,
      8'd255, 8'd255, 8'd255,  8'd0,   8'd255, 8'd0,
      8'd0,   8'd0,   8'd0,    8'd1,   8'd254, 8'd128,
      8'd127, 8'd255, 8'd0,    8'd0,   8'd0,   8'd255
   };

   typedef struct {
      logic [PIX_W-1:0]     pixel;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] column;
      logic                 last_of_run;
      logic                 frame_end;
   } out_pixel_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [OUT_COL_W-1:0]  rsp_out_column;
   logic                  rsp_last_of_run;
   logic                  rsp_frame_end;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Stimulus and scoreboard bookkeeping
   logic [PIX_W-1:0] pixel_q [$];
   out_pixel_type    filtered_q [$];
   int               issued_count = 0;
   int               accepted_count = 0;
   int               random_items = 0;
   int               fail_count = 0;
   int               cycle_count = 0;
   int               gap_left = 0;
   int               hold_left = 0;
   logic             send_idle = 1'b0;
   logic             recv_idle = 1'b0;

   // Filter state mirrored from the block
   logic [WIDTH_W-1:0] cfg_width  = RESET_WIDTH;
   logic [ROW_W-1:0]   cfg_height = RESET_HEIGHT;
   logic [KSEL_W-1:0]  cfg_kernel = KERNEL_BOX;
   logic [PIX_W-1:0]   row_prev  [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]   row_older [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]   taps [3][3] = '{default: '0};
   int unsigned        cur_row = 0;
   int unsigned        cur_col = 0;

   image_convolution_3x3 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // Weighted 3x3 sum of the window, divided for box and Gaussian, clamped to the pixel range
   function automatic logic [PIX_W-1:0] convolve_window();
      int p [9];
      int acc;
      for (int i = 0; i < 9; i++) p[i] = taps[i / 3][i % 3];
      case (cfg_kernel)
         KERNEL_BOX: begin
            acc = (p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8]) / 9;
         end
         KERNEL_GAUSSIAN: begin
            acc = (p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5]
                   + p[6] + 2 * p[7] + p[8]) / 16;
         end
         KERNEL_OUTLINE: begin
            acc = 8 * p[4] - (p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8]);
         end
         KERNEL_EMBOSS: begin
            acc = -2 * p[0] - p[1] - p[3] + p[4] + p[5] + p[7] + 2 * p[8];
         end
         KERNEL_SHARPEN: begin
            acc = 5 * p[4] - p[1] - p[3] - p[5] - p[7];
         end
         default: begin
            acc = p[4];
         end
      endcase
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return PIX_W'(acc);
   endfunction

   // One pixel into the frame: update position, window and line stores,
   // queue the border copy and/or the interior pixel it completes
   task automatic advance_frame(input logic [PIX_W-1:0] pix);
      int unsigned   w, h, r, c;
      out_pixel_type res [2];
      int            n;
      int            i;
      w = eff_width();
      h = eff_height();
      n = 0;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= h) cur_row = 0;
      r = cur_row;
      c = cur_col;
      for (i = 0; i < 3; i++) begin
         taps[i][0] = taps[i][1];
         taps[i][1] = taps[i][2];
      end
      taps[0][2] = row_older[c];
      taps[1][2] = row_prev[c];
      taps[2][2] = pix;
      row_older[c] = row_prev[c];
      row_prev[c] = pix;
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
         res[n] = '{pix, ROW_W'(r), OUT_COL_W'(c), 1'b0, 1'b0};
         n++;
      end
      if (r >= 2 && c >= 2) begin
         res[n] = '{convolve_window(), ROW_W'(r - 1), OUT_COL_W'(c - 1), 1'b0, 1'b0};
         n++;
      end
      if (n > 0) begin
         res[n - 1].last_of_run = 1'b1;
         res[n - 1].frame_end = (r == h - 1) && (c == w - 1);
      end
      for (i = 0; i < n; i++) filtered_q.push_back(res[i]);
      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
      end
   endtask

   // Pixels still needed to close the current frame
   function automatic int frame_left();
      int unsigned w, h, r, c;
      w = eff_width();
      h = eff_height();
      r = cur_row;
      c = cur_col;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) r = 0;
      return (r == 0 && c == 0) ? 0 : int'((h - r) * w - c);
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(input logic enable);
      int roll;
      if (!enable) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_frame(req_pixel_in);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               req_valid <= 1'b1;
               req_pixel_in <= pixel_q.pop_front();
               gap_left = pick_gap(send_idle);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_output();
      out_pixel_type want;
      if (filtered_q.size() == 0) begin
         $error("unexpected output: pixel %0d row %0d column %0d",
                rsp_pixel_out, rsp_out_row, rsp_out_column);
         fail_count++;
      end else begin
         want = filtered_q.pop_front();
         if (rsp_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, rsp_pixel_out);
            fail_count++;
         end
         if (rsp_out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, rsp_out_row);
            fail_count++;
         end
         if (rsp_out_column !== want.column) begin
            $error("out_column: expected %0d, actual %0d", want.column, rsp_out_column);
            fail_count++;
         end
         if (rsp_last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   rsp_last_of_run);
            fail_count++;
         end
         if (rsp_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end, rsp_frame_end);
            fail_count++;
         end
      end
   endtask

   // Output monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_output();
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            hold_left = pick_gap(recv_idle);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Wait until every request is taken and every output has come back,
   // then cover the pipeline for requests that produce nothing
   task automatic settle();
      while (accepted_count != issued_count || filtered_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_index <= idx;
      csr_data <= value;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_width = value[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT:  cfg_height = value[ROW_W-1:0];
         CSR_KERNEL_SELECT: cfg_kernel = value[KSEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] pix);
      pixel_q.push_back(pix);
      issued_count++;
   endtask

   task automatic send_pixels(input int n);
      repeat (n) push_pixel(rand_pixel());
      random_items += n;
   endtask

   // Stimulus
   initial begin
      logic [KSEL_W-1:0] kernel_seq [6];
      int unsigned w, h, k, nw;
      int          choice;
      kernel_seq = '{KERNEL_BOX, KERNEL_GAUSSIAN, KERNEL_OUTLINE,
                     KERNEL_EMBOSS, KERNEL_SHARPEN, KERNEL_UNKNOWN};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 3-wide frame, one interior pixel per row, new kernel each row
      write_reg(CSR_IMAGE_WIDTH, 16'd3);
      write_reg(CSR_IMAGE_HEIGHT, 16'd8);
      write_reg(CSR_KERNEL_SELECT, {13'd0, KERNEL_BOX});
      write_reg(CSR_UNUSED, 16'hFFFF);
      for (int i = 0; i < 6; i++) push_pixel(DIRECTED_PIX[i]);
      for (int row = 0; row < 6; row++) begin
         write_reg(CSR_KERNEL_SELECT, {13'd0, kernel_seq[row]});
         for (int i = 0; i < 3; i++) push_pixel(DIRECTED_PIX[6 + 3 * row + i]);
      end

      // Width above the maximum, shrunk mid-row to force a wrap
      send_idle = 1'b1;
      recv_idle = 1'b1;
      write_reg(CSR_IMAGE_WIDTH, 16'h07FF);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3);
      write_reg(CSR_KERNEL_SELECT, 16'($urandom_range(0, 7)));
      send_pixels(520);
      write_reg(CSR_IMAGE_WIDTH, 16'd4);
      send_pixels(frame_left());

      // Maximum width, shrunk on the first row
      write_reg(CSR_IMAGE_WIDTH, 16'd1024);
      write_reg(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixels(30);
      write_reg(CSR_IMAGE_WIDTH, 16'd3);
      send_pixels(frame_left());

      // Single column at maximum height, then height cut below the row
      write_reg(CSR_IMAGE_WIDTH, 16'd1);
      write_reg(CSR_IMAGE_HEIGHT, 16'hFFFF);
      send_pixels(20);
      write_reg(CSR_IMAGE_HEIGHT, 16'd5);
      send_pixels(frame_left());

      // Zero width and height act as a 1x1 frame
      write_reg(CSR_IMAGE_WIDTH, 16'd0);
      write_reg(CSR_IMAGE_HEIGHT, 16'd0);
      send_pixels(10);

      // Random frames, mostly small
      while (random_items < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0: w = $urandom_range(1, 2);
            1: w = $urandom_range(17, 40);
            default: w = $urandom_range(3, 16);
         endcase
         h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         write_reg(CSR_IMAGE_WIDTH, {5'($urandom), 11'(w)});
         write_reg(CSR_IMAGE_HEIGHT, 16'(h));
         write_reg(CSR_KERNEL_SELECT, {13'($urandom), 3'($urandom_range(0, 7))});
         choice = $urandom_range(0, 7);
         if (choice == 0) begin
            // kernel swap mid-frame
            send_pixels((w * h) / 2);
            write_reg(CSR_KERNEL_SELECT, {13'd0, 3'($urandom_range(0, 7))});
         end else if (choice == 1 && w >= 4 && h >= 3) begin
            // width cut below the current column on the second row
            k = $urandom_range(1, w - 1);
            send_pixels(w + k);
            nw = $urandom_range(0, k);
            write_reg(CSR_IMAGE_WIDTH, 16'(nw));
         end else if (choice == 2 && h >= 3) begin
            // height cut below the current row
            k = $urandom_range(0, w - 1);
            send_pixels(2 * w + k);
            write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(0, 2)));
         end
         send_pixels(frame_left());
         settle();
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
